// ----- hdl/tcnw_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and helpers of the text console number writer
// no dependencies; imported by the controller, the datapath and the top level
package tcnw_pkg;

  localparam int SCREEN_WIDTH  = 80;
  localparam int SCREEN_HEIGHT = 25;
  localparam int DIGIT_DEPTH   = 32;

  localparam int COL_W   = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
  localparam int ROW_W   = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
  localparam int DIDX_W  = $clog2(DIGIT_DEPTH);
  localparam int DCNT_W  = $clog2(DIGIT_DEPTH + 1);

  localparam logic [7:0] MINUS_CHAR = 8'h2d;
  localparam logic [4:0] RADIX_MIN  = 5'd2;
  localparam logic [4:0] RADIX_MAX  = 5'd16;
  localparam logic [4:0] RADIX_DEC  = 5'd10;

  typedef enum logic [1:0] {
    CMD_PUT_CHAR     = 2'd0,
    CMD_PUT_UNSIGNED = 2'd1,
    CMD_PUT_SIGNED   = 2'd2,
    CMD_UNUSED       = 2'd3
  } command_t;

  typedef enum logic [1:0] {
    REG_TEXT_COLOR     = 2'd0,
    REG_NEWLINE_CODE   = 2'd1,
    REG_BACKSPACE_CODE = 2'd2,
    REG_BLANK_CODE     = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  char_code;
    logic [31:0] number;
    logic [4:0]  radix;
  } in_item_t;

  typedef struct packed {
    logic [10:0] cell_index;
    logic [15:0] cell_word;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic put;
    logic div_step;
    logic pop;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic put_blocked;
    logic fin_blocked;
    logic div_finish;
    logic digits_empty;
  } dp_status_t;

  // digit value to its character, lower-case letters above nine
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) c = 8'h30 + {4'd0, d};
    else c = 8'h57 + {4'd0, d};
    return c;
  endfunction

endpackage

// ----- hdl/tcnw_controller.sv -----
`timescale 1ns / 1ps
// sequencing state machine of the text console number writer
// depends on tcnw_pkg; drives the datapath through dp_cmd_t
module tcnw_controller (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  tcnw_pkg::in_item_t    in_data,
  input  tcnw_pkg::dp_status_t  status,
  output tcnw_pkg::dp_cmd_t     cmd
);
  import tcnw_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_PUT_CHAR  = 7'b0000010,
    S_PUT_MINUS = 7'b0000100,
    S_DIV       = 7'b0001000,
    S_POP       = 7'b0010000,
    S_PUT_DIGIT = 7'b0100000,
    S_FINISH    = 7'b1000000
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (command_t'(in_data.command))
            CMD_PUT_CHAR:     state_next = S_PUT_CHAR;
            CMD_PUT_UNSIGNED: state_next = S_DIV;
            CMD_PUT_SIGNED:   state_next = in_data.number[31] ? S_PUT_MINUS : S_DIV;
            default:          state_next = S_FINISH;
          endcase
        end
      end
      S_PUT_CHAR: begin
        cmd.put = 1'b1;
        if (!status.put_blocked) state_next = S_FINISH;
      end
      S_PUT_MINUS: begin
        cmd.put = 1'b1;
        if (!status.put_blocked) state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_finish) state_next = S_POP;
      end
      S_POP: begin
        if (status.digits_empty) begin
          state_next = S_FINISH;
        end else begin
          cmd.pop = 1'b1;
          state_next = S_PUT_DIGIT;
        end
      end
      S_PUT_DIGIT: begin
        cmd.put = 1'b1;
        if (!status.put_blocked) state_next = S_POP;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        if (!status.fin_blocked) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

// ----- hdl/tcnw_datapath.sv -----
`timescale 1ns / 1ps
// cursor, digit conversion, config registers and output register
// depends on tcnw_pkg; controlled by tcnw_controller through dp_cmd_t
module tcnw_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  tcnw_pkg::in_item_t    in_data,
  input  tcnw_pkg::dp_cmd_t     cmd,
  output tcnw_pkg::dp_status_t  status,
  input  logic                  cfg_valid,
  input  logic [1:0]            cfg_index,
  input  logic [7:0]            cfg_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output tcnw_pkg::out_item_t   out_data
);
  import tcnw_pkg::*;

  // config registers
  logic [7:0] text_color, newline_code, backspace_code, blank_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color     <= 8'd7;
      newline_code   <= 8'd10;
      backspace_code <= 8'd8;
      blank_code     <= 8'd32;
    end else if (cfg_valid) begin
      unique case (reg_index_t'(cfg_index))
        REG_TEXT_COLOR:     text_color     <= cfg_data;
        REG_NEWLINE_CODE:   newline_code   <= cfg_data;
        REG_BACKSPACE_CODE: backspace_code <= cfg_data;
        REG_BLANK_CODE:     blank_code     <= cfg_data;
        default: ;
      endcase
    end
  end

  // conversion state
  logic [31:0]       value;
  logic [4:0]        radix;
  logic [3:0]        rem;
  logic [1:0]        step_cnt;
  logic [DCNT_W-1:0] n;
  logic [3:0]        digit_store [DIGIT_DEPTH];
  logic [7:0]        ch;

  logic [4:0]        r;
  logic [31:0]       q;
  logic [4:0]        radix_load;
  logic [31:0]       value_load;
  logic [DCNT_W-1:0] n_dec;

  always_comb begin
    // eight bits of restoring long division by the radix
    r = {1'b0, rem};
    q = value;
    for (int i = 0; i < 8; i++) begin
      r = {r[3:0], q[31]};
      q = {q[30:0], 1'b0};
      if (r >= radix) begin
        r = r - radix;
        q[0] = 1'b1;
      end
    end
  end

  always_comb begin
    radix_load = RADIX_DEC;
    value_load = in_data.number;
    if (command_t'(in_data.command) == CMD_PUT_UNSIGNED) begin
      if (in_data.radix < RADIX_MIN) radix_load = RADIX_MIN;
      else if (in_data.radix > RADIX_MAX) radix_load = RADIX_MAX;
      else radix_load = in_data.radix;
    end else if (in_data.number[31]) begin
      value_load = (~in_data.number) + 32'd1;
    end
  end

  assign n_dec = n - DCNT_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value    <= value_load;
      radix    <= radix_load;
      rem      <= '0;
      step_cnt <= '0;
      n        <= '0;
      if (command_t'(in_data.command) == CMD_PUT_CHAR) ch <= in_data.char_code;
      else ch <= MINUS_CHAR;
    end else if (cmd.div_step) begin
      value    <= q;
      step_cnt <= step_cnt + 2'd1;
      if (step_cnt == 2'd3) begin
        digit_store[n[DIDX_W-1:0]] <= r[3:0];
        n   <= n + DCNT_W'(1);
        rem <= '0;
      end else begin
        rem <= r[3:0];
      end
    end else if (cmd.pop) begin
      ch <= digit_char(digit_store[n_dec[DIDX_W-1:0]]);
      n  <= n_dec;
    end
  end

  // cursor and character handling
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;
  logic             is_nl, is_bs, emit;
  logic [COL_W-1:0] emit_col;
  logic [7:0]       emit_char;
  logic [15:0]      lin_index;
  logic [ROW_W-1:0] row_adv;

  // the newest cell is held back until it is known whether it ends the item
  out_item_t held;
  logic      held_valid;
  logic      out_free;
  logic      put_go, fin_go;

  assign out_free  = !out_valid || !out_stall;
  assign is_nl     = (ch == newline_code);
  assign is_bs     = !is_nl && (ch == backspace_code);
  assign emit      = !is_nl && (!is_bs || (col != '0));
  assign emit_col  = is_bs ? col - COL_W'(1) : col;
  assign emit_char = is_bs ? blank_code : ch;
  assign lin_index = 16'(row) * 16'(SCREEN_WIDTH) + 16'(emit_col);
  assign row_adv   = (row == ROW_W'(SCREEN_HEIGHT - 1)) ? '0 : row + ROW_W'(1);

  assign status.put_blocked  = emit && held_valid && !out_free;
  assign status.fin_blocked  = held_valid && !out_free;
  assign status.div_finish   = (step_cnt == 2'd3) &&
                               ((q == 32'd0) || (n == DCNT_W'(DIGIT_DEPTH - 1)));
  assign status.digits_empty = (n == '0);

  assign put_go = cmd.put && !status.put_blocked;
  assign fin_go = cmd.finish && held_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      row        <= '0;
      col        <= '0;
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (put_go) begin
        if (is_nl) begin
          col <= '0;
          row <= row_adv;
        end else if (is_bs) begin
          if (col != '0) col <= col - COL_W'(1);
        end else if (col == COL_W'(SCREEN_WIDTH - 1)) begin
          col <= '0;
          row <= row_adv;
        end else begin
          col <= col + COL_W'(1);
        end
      end
      if (fin_go) held_valid <= 1'b0;
      else if (put_go && emit) held_valid <= 1'b1;
      if (fin_go || (put_go && emit && held_valid)) out_valid <= 1'b1;
      else if (out_free) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (put_go && emit) begin
      held.cell_index <= lin_index[10:0];
      held.cell_word  <= {text_color, emit_char};
      held.last       <= 1'b0;
    end
    if (fin_go) out_data <= {held.cell_index, held.cell_word, 1'b1};
    else if (put_go && emit && held_valid) out_data <= held;
  end

endmodule

// ----- hdl/text_console_number_writer.sv -----
`timescale 1ns / 1ps
// top level of the text console number writer
// depends on tcnw_pkg, tcnw_controller and tcnw_datapath
//
// Takes one item at a time and writes screen cells at a text cursor. A
// number is converted by restoring long division, eight quotient bits per
// cycle; its digits come out least significant first, are stored, and are
// then written out most significant first, and the output side can stall
// the writing. The most recent cell is held back until the next cell or
// the end of the item, so that the final cell of an item carries last;
// an item that writes no cell produces no output. Configuration writes are
// always ready and must only be issued while the block is idle.
module text_console_number_writer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tcnw_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tcnw_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [7:0]           cfg_data
);
  import tcnw_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  tcnw_controller u_controller (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .status   (status),
    .cmd      (cmd)
  );

  tcnw_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- bench/console_cell_checker.sv -----
`timescale 1ns / 1ps
// checker for the text console number writer: watches the item, cell and config channels,
// predicts every cell write from its own cursor model and compares; depends on tcnw_pkg
module console_cell_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  tcnw_pkg::in_item_t   in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  tcnw_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [7:0]           cfg_data,
  output int                   fail_count,
  output int                   pending,
  output int                   cells_checked
);
  import tcnw_pkg::*;

  // console settings as last written
  logic [7:0] color;
  logic [7:0] newline_code;
  logic [7:0] backspace_code;
  logic [7:0] blank_code;

  int unsigned cur_row;
  int unsigned cur_col;
  out_item_t   cell_queue[$];
  int          fails = 0;
  int          checked = 0;

  function automatic void emit_cell(input logic [7:0] glyph);
    out_item_t c;
    c.cell_index = 11'(cur_row * SCREEN_WIDTH + cur_col);
    c.cell_word  = {color, glyph};
    c.last       = 1'b0;
    cell_queue.push_back(c);
  endfunction

  function automatic void next_row();
    cur_row = (cur_row + 1 >= SCREEN_HEIGHT) ? 0 : cur_row + 1;
  endfunction

  function automatic void put_glyph(input logic [7:0] glyph);
    if (glyph == newline_code) begin
      cur_col = 0;
      next_row();
    end else if (glyph == backspace_code) begin
      if (cur_col != 0) begin
        cur_col = cur_col - 1;
        emit_cell(blank_code);
      end
    end else begin
      emit_cell(glyph);
      cur_col = cur_col + 1;
      if (cur_col >= SCREEN_WIDTH) begin
        cur_col = 0;
        next_row();
      end
    end
  endfunction

  // digits come out least significant first, so they are stacked and written back
  function automatic void put_digits(input logic [31:0] value, input logic [4:0] base);
    logic [3:0]  digit_stack[$];
    logic [31:0] rest;
    logic [3:0]  d;
    rest = value;
    do begin
      digit_stack.push_back(4'(rest % 32'(base)));
      rest = rest / 32'(base);
    end while (rest != 0 && digit_stack.size() < DIGIT_DEPTH);
    while (digit_stack.size() > 0) begin
      d = digit_stack.pop_back();
      put_glyph((d < 4'd10) ? 8'h30 + 8'(d) : 8'h57 + 8'(d));
    end
  endfunction

  function automatic void predict_cells(input in_item_t item);
    int          queued;
    logic [4:0]  base;
    logic [31:0] value;
    out_item_t   tail;
    queued = cell_queue.size();
    case (command_t'(item.command))
      CMD_PUT_CHAR: put_glyph(item.char_code);
      CMD_PUT_UNSIGNED: begin
        base = item.radix;
        if (base < RADIX_MIN) base = RADIX_MIN;
        if (base > RADIX_MAX) base = RADIX_MAX;
        put_digits(item.number, base);
      end
      CMD_PUT_SIGNED: begin
        value = item.number;
        if (value[31]) begin
          put_glyph(MINUS_CHAR);
          value = ~value + 32'd1;
        end
        put_digits(value, RADIX_DEC);
      end
      default: ;
    endcase
    if (cell_queue.size() > queued) begin
      tail = cell_queue.pop_back();
      tail.last = 1'b1;
      cell_queue.push_back(tail);
    end
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst) begin
      color          = 8'd7;
      newline_code   = 8'd10;
      backspace_code = 8'd8;
      blank_code     = 8'd32;
      cur_row        = 0;
      cur_col        = 0;
      cell_queue.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_index_t'(cfg_index))
          REG_TEXT_COLOR:     color = cfg_data;
          REG_NEWLINE_CODE:   newline_code = cfg_data;
          REG_BACKSPACE_CODE: backspace_code = cfg_data;
          REG_BLANK_CODE:     blank_code = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_cells(in_data);
      if (out_valid && !out_stall) begin
        checked++;
        if (cell_queue.size() == 0) begin
          $display("%0t: unexpected cell index %0d word %h last %b", $time,
                   out_data.cell_index, out_data.cell_word, out_data.last);
          fails++;
        end else begin
          want = cell_queue.pop_front();
          if (out_data.cell_index !== want.cell_index || out_data.cell_word !== want.cell_word ||
              out_data.last !== want.last) begin
            $display("%0t: cell mismatch expected index %0d word %h last %b, got %0d %h %b",
                     $time, want.cell_index, want.cell_word, want.last,
                     out_data.cell_index, out_data.cell_word, out_data.last);
            fails++;
          end
        end
      end
    end
    fail_count    <= fails;
    pending       <= cell_queue.size();
    cells_checked <= checked;
  end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// testbench top for the text console number writer: clock, reset, config writes and
// item stimulus with random gaps; depends on tcnw_pkg, console_cell_checker and the block
module tb;
  import tcnw_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 500;
  localparam int LONG_HOLD      = 400;

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  int fail_count;
  int pending;
  int cells_checked;

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          hold_request = 1'b0;
  int          items_sent = 0;
  int          settings_used = 1;
  int          quiet_cycles = 0;
  logic [7:0]  cur_newline = 8'd10;
  logic [7:0]  cur_backspace = 8'd8;

  text_console_number_writer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  console_cell_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .cells_checked(cells_checked)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no channel moved for %0d cycles", $time, quiet_cycles);
      $display("Verification failed");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  // cell side: random stall, or one long hold when asked
  initial begin : cell_sink
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && hold_left == 0) begin
        hold_left = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic in_item_t make_item(input command_t cmd, input logic [7:0] ch,
                                         input logic [31:0] num, input logic [4:0] base);
    in_item_t it;
    it.command   = cmd;
    it.char_code = ch;
    it.number    = num;
    it.radix     = base;
    return it;
  endfunction

  // mostly characters, printable ones with control codes and random bytes mixed in, numbers of random length
  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    it = make_item(CMD_PUT_CHAR, 8'($urandom), $urandom, 5'($urandom));
    pick = $urandom_range(99);
    if (pick < 40) it.char_code = 8'($urandom_range(126, 32));
    else if (pick < 50) it.char_code = cur_newline;
    else if (pick < 58) it.char_code = cur_backspace;
    else if (pick < 66) ;
    else if (pick < 84) begin
      it.command = CMD_PUT_UNSIGNED;
      it.number = $urandom >> $urandom_range(31);
      if ($urandom_range(3) != 0) it.radix = 5'($urandom_range(16, 2));
    end else if (pick < 97) begin
      it.command = CMD_PUT_SIGNED;
      it.number = $urandom >> $urandom_range(31);
      if ($urandom_range(1) == 1) it.number = ~it.number + 32'd1;
    end else
      it.command = CMD_UNUSED;
    return it;
  endfunction

  task automatic send_item(input in_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    items_sent++;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_item(random_item());
  endtask

  // wait for every expected cell, then optionally for items that write nothing
  task automatic drain(input bit settle);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_console(input logic [7:0] color, input logic [7:0] nl,
                             input logic [7:0] bs, input logic [7:0] blank);
    write_reg(REG_TEXT_COLOR, color);
    write_reg(REG_NEWLINE_CODE, nl);
    write_reg(REG_BACKSPACE_CODE, bs);
    write_reg(REG_BLANK_CODE, blank);
    cfg_valid <= 1'b0;
    cur_newline   = nl;
    cur_backspace = bs;
    settings_used++;
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset settings, directed corners
    send_idle_pct = 34;
    recv_idle_pct = 49;
    send_item(make_item(CMD_PUT_CHAR, 8'h41, 32'd0, 5'd0));
    send_item(make_item(CMD_PUT_CHAR, 8'h00, 32'd0, 5'd0));
    send_item(make_item(CMD_PUT_CHAR, 8'hff, 32'd0, 5'd0));
    send_item(make_item(CMD_PUT_CHAR, 8'd8, 32'd0, 5'd0));
    send_item(make_item(CMD_PUT_CHAR, 8'd10, 32'd0, 5'd0));
    // backspace at column zero writes nothing
    send_item(make_item(CMD_PUT_CHAR, 8'd8, 32'd0, 5'd0));
    send_item(make_item(CMD_UNUSED, 8'hff, 32'hffff_ffff, 5'h1f));
    send_item(make_item(CMD_PUT_UNSIGNED, 8'h00, 32'd0, 5'd10));
    send_item(make_item(CMD_PUT_UNSIGNED, 8'h00, 32'hffff_ffff, 5'd2));
    send_item(make_item(CMD_PUT_UNSIGNED, 8'h00, 32'hffff_ffff, 5'd16));
    // out of range radix clamps to two or sixteen
    send_item(make_item(CMD_PUT_UNSIGNED, 8'h00, 32'hdead_beef, 5'd0));
    send_item(make_item(CMD_PUT_UNSIGNED, 8'h00, 32'd12345, 5'd1));
    send_item(make_item(CMD_PUT_UNSIGNED, 8'h00, 32'h1234_5678, 5'd17));
    send_item(make_item(CMD_PUT_UNSIGNED, 8'h00, 32'hffff_ffff, 5'd31));
    send_item(make_item(CMD_PUT_UNSIGNED, 8'h00, 32'd1234567890, 5'd10));
    send_item(make_item(CMD_PUT_UNSIGNED, 8'h00, 32'h7fff_ffff, 5'd3));
    send_item(make_item(CMD_PUT_SIGNED, 8'h00, 32'h8000_0000, 5'd0));
    send_item(make_item(CMD_PUT_SIGNED, 8'h00, 32'hffff_ffff, 5'd0));
    send_item(make_item(CMD_PUT_SIGNED, 8'h00, 32'h7fff_ffff, 5'd0));
    send_item(make_item(CMD_PUT_SIGNED, 8'h00, 32'd0, 5'd0));
    send_random(45);
    drain(1'b1);

    // digits and minus that collide with control codes
    set_console(8'h00, 8'h30, MINUS_CHAR, 8'hff);
    send_item(make_item(CMD_PUT_UNSIGNED, 8'h00, 32'd1000, 5'd10));
    send_item(make_item(CMD_PUT_CHAR, 8'h78, 32'd0, 5'd0));
    send_item(make_item(CMD_PUT_SIGNED, 8'h00, 32'hffff_ffd6, 5'd0));
    send_random(45);
    drain(1'b1);

    // newline and backspace on one code
    send_idle_pct = 49;
    recv_idle_pct = 34;
    set_console(8'hff, 8'h41, 8'h41, 8'h00);
    send_item(make_item(CMD_PUT_CHAR, 8'h41, 32'd0, 5'd0));
    send_random(25);
    drain(1'b0);
    send_random(25);
    drain(1'b1);

    // no gaps; one long hold on the cell side while items keep coming
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_console(8'h1e, 8'hff, 8'h00, 8'h2e);
    hold_request = 1'b1;
    send_random(57);
    drain(1'b1);

    $display("sent %0d items under %0d console settings, %0d cells checked",
             items_sent, settings_used, cells_checked);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/tcnw_pkg.sv
hdl/tcnw_controller.sv
hdl/tcnw_datapath.sv
hdl/text_console_number_writer.sv
bench/console_cell_checker.sv
bench/tb.sv
